### design/ffca_pkg.sv
// shared types and constants of the first-fit coalescing allocator
package ffca_pkg;

  localparam int REQ_BYTES_W = 32;
  localparam int BLK_ADDR_W  = 17;
  localparam int ADDR_W      = 17;
  localparam int CFG_W       = 18;
  localparam int SIZE_W      = 17;
  localparam int KEY_W       = 18;
  localparam int TOTAL_W     = 34;
  localparam int WORDS_W     = 15;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 18'h20000;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_NO_FIT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WM_FIT     = 2'd0,
    WM_ENDS_AT = 2'd1,
    WM_IS      = 2'd2
  } walk_mode_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FHDR, S_FHDR_RD, S_WSTART, S_WRD, S_WEV, S_AUNL,
    S_ASPLIT, S_AWR, S_FMERGE1, S_FMERGE2, S_FPUSH, S_DONE
  } state_e;

endpackage

### design/ffca_ram.sv
// generic simple dual-port ram with registered read
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ffca_mod.sv
// wrap of a word address into the arena, the arena size being a power of two
module ffca_mod #(
  parameter int VW = 18,
  parameter int RW = 4
) (
  input  logic [VW-1:0] value_i,
  output logic [RW-1:0] result_o
);

  // modulo by a power of two keeps the low bits
  assign result_o = value_i[RW-1:0];

endmodule

### design/first_fit_coalescing_allocator.sv
// first-fit allocator with coalescing frees, free lists kept in header memories
// an allocate walks the free list for the first region that fits and may split it, and
//   a free walks the list twice
// throughput: one request at a time, the next is taken once done_o has pulsed
// reset and each configuration write sweep the arenas with busy high
// the result is shown for one cycle on done_o, the receiver cannot stall it
module first_fit_coalescing_allocator
  import ffca_pkg::*;
#(
  parameter int ARENAS      = 4,
  parameter int ARENA_WORDS = 16384
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic [1:0]             arena_i,
  input  logic [REQ_BYTES_W-1:0] request_bytes_i,
  input  logic [BLK_ADDR_W-1:0]  block_addr_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output logic                   done_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [ADDR_W-1:0]      addr_o
);

  localparam int AIDX  = (ARENAS > 1) ? $clog2(ARENAS) : 1;
  localparam int WW    = $clog2(ARENA_WORDS);
  localparam int NB    = $clog2(ARENA_WORDS + 1);
  localparam int SW    = $clog2(ARENA_WORDS + 2);
  localparam int DEPTH = (1 << AIDX) << WW;
  localparam int MAW   = AIDX + WW;
  localparam logic [NB-1:0]     NIL      = NB'(ARENA_WORDS);
  localparam logic [SW-1:0]     STEP_MAX = SW'(ARENA_WORDS);
  localparam logic [SIZE_W-1:0] AW_SIZE  = SIZE_W'(ARENA_WORDS);

  state_e              state_q, state_d;
  logic [AIDX-1:0]     ia_q, ia_d;
  logic [CFG_W-1:0]    arena_q;
  logic [NB-1:0]       head_q [ARENAS];
  logic [AIDX-1:0]     a_q, a_d;
  req_e                req_q, req_d;
  logic [WORDS_W-1:0]  words_q, words_d;
  logic [KEY_W-1:0]    key_q, key_d;
  walk_mode_e          mode_q, mode_d;
  logic [NB-1:0]       it_q, it_d;
  logic [WW-1:0]       prev_q, prev_d;
  logic                hp_q, hp_d;
  logic [SW-1:0]       steps_q, steps_d;
  logic [WW-1:0]       hit_q, hit_d;
  logic [SIZE_W-1:0]   hsz_q, hsz_d;
  logic [NB-1:0]       hnext_q, hnext_d;
  logic [NB-1:0]       headnext_q, headnext_d;
  logic                found_q, found_d;
  logic [SIZE_W-1:0]   szblk_q, szblk_d;
  logic [WW-1:0]       cur_q, cur_d;
  logic [SIZE_W-1:0]   cursz_q, cursz_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;

  // memory ports
  logic              size_we, next_we;
  logic [MAW-1:0]    size_waddr, next_waddr, raddr;
  logic [SIZE_W-1:0] size_wdata, size_rd;
  logic [NB-1:0]     next_wdata, next_rd;

  // head update
  logic              head_we;
  logic [NB-1:0]     head_wval;

  // address wrap
  logic [KEY_W-1:0]  mod_value;
  logic [WW-1:0]     mod_res;

  // combinational helpers
  logic [NB-1:0]       head_cur;
  logic [AIDX-1:0]     arena_red;
  logic [TOTAL_W-1:0]  total;
  logic                too_big;
  logic [BLK_ADDR_W-4:0] blk_w;
  logic                free_bad;
  logic [ADDR_W-1:0]   blk_ext;
  logic                in_list, match;
  logic [KEY_W-1:0]    ends_sum;
  logic [SIZE_W-1:0]   cfg_words;
  logic [SIZE_W-1:0]   split_sz, merge1_sz, merge2_sz;
  logic [ADDR_W-1:0]   hit_p1;

  // unlink decisions
  logic              unl_head_we;
  logic [NB-1:0]     unl_head_val;
  logic              unl_next_we;
  logic [WW-1:0]     unl_next_addr;
  logic [NB-1:0]     unl_next_val;

  ffca_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (raddr),
    .rdata_o (size_rd)
  );

  ffca_ram #(.WIDTH(NB), .DEPTH(DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (raddr),
    .rdata_o (next_rd)
  );

  ffca_mod #(.VW(KEY_W), .RW(WW)) u_mod (
    .value_i  (mod_value),
    .result_o (mod_res)
  );

  assign head_cur = head_q[a_q];

  // arena index modulo arena count, three subtract steps at most
  always_comb begin
    logic [4:0] v;
    v = {3'b000, arena_i};
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(ARENAS)) begin
        v = v - 5'(ARENAS);
      end
    end
    arena_red = AIDX'(v);
  end

  assign total     = ((TOTAL_W'(request_bytes_i) + TOTAL_W'(15)) & ~TOTAL_W'(15))
                     + TOTAL_W'(8);
  assign too_big   = total > TOTAL_W'(arena_q);
  assign blk_w     = block_addr_i[BLK_ADDR_W-1:3];
  assign free_bad  = (blk_w == '0) || (ADDR_W'(blk_w) > ADDR_W'(ARENA_WORDS));
  assign blk_ext   = ADDR_W'(blk_w) - ADDR_W'(1);
  assign in_list   = (it_q < NIL) && (steps_q <= STEP_MAX);
  assign ends_sum  = KEY_W'(it_q) + KEY_W'(size_rd);
  assign cfg_words = (SIZE_W'(arena_q[CFG_W-1:3]) > AW_SIZE) ? AW_SIZE
                                                             : SIZE_W'(arena_q[CFG_W-1:3]);
  assign split_sz  = hsz_q - SIZE_W'(words_q);
  assign merge1_sz = hsz_q + szblk_q;
  assign merge2_sz = cursz_q + hsz_q;
  assign hit_p1    = ADDR_W'(hit_q) + ADDR_W'(1);

  always_comb begin
    unique case (mode_q)
      WM_FIT:     match = KEY_W'(size_rd) >= key_q;
      WM_ENDS_AT: match = ends_sum == key_q;
      WM_IS:      match = KEY_W'(it_q) == key_q;
      default:    match = 1'b0;
    endcase
  end

  // unlink of the region found by the last walk
  always_comb begin
    unl_head_we   = 1'b0;
    unl_head_val  = hnext_q;
    unl_next_we   = 1'b0;
    unl_next_addr = prev_q;
    unl_next_val  = hnext_q;
    if (headnext_q >= NIL) begin
      // last region: list becomes empty
      unl_head_we   = 1'b1;
      unl_head_val  = NIL;
      unl_next_we   = 1'b1;
      unl_next_addr = hit_q;
      unl_next_val  = NIL;
    end else if (!hp_q) begin
      unl_head_we = 1'b1;
    end else begin
      unl_next_we = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (ia_q == AIDX'(ARENAS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_ALLOC) begin
            state_d = too_big ? S_DONE : S_WSTART;
          end else begin
            state_d = free_bad ? S_DONE : S_FHDR;
          end
        end
      end
      S_FHDR:    state_d = S_FHDR_RD;
      S_FHDR_RD: state_d = S_WSTART;
      S_WSTART:  state_d = S_WRD;
      S_WRD: begin
        if (in_list) begin
          state_d = S_WEV;
        end else begin
          unique case (mode_q)
            WM_FIT:     state_d = S_DONE;
            WM_ENDS_AT: state_d = S_FMERGE1;
            default:    state_d = S_FMERGE2;
          endcase
        end
      end
      S_WEV: begin
        if (!match) begin
          state_d = S_WRD;
        end else begin
          unique case (mode_q)
            WM_FIT:     state_d = (size_rd == SIZE_W'(words_q)) ? S_AUNL : S_ASPLIT;
            WM_ENDS_AT: state_d = S_FMERGE1;
            default:    state_d = S_FMERGE2;
          endcase
        end
      end
      S_AUNL:    state_d = S_DONE;
      S_ASPLIT:  state_d = S_AWR;
      S_AWR:     state_d = S_DONE;
      S_FMERGE1: state_d = S_WSTART;
      S_FMERGE2: state_d = S_FPUSH;
      S_FPUSH:   state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
    if (cfg_we_i) state_d = S_INIT;
  end

  // datapath and memory controls
  always_comb begin
    ia_d       = ia_q;
    a_d        = a_q;
    req_d      = req_q;
    words_d    = words_q;
    key_d      = key_q;
    mode_d     = mode_q;
    it_d       = it_q;
    prev_d     = prev_q;
    hp_d       = hp_q;
    steps_d    = steps_q;
    hit_d      = hit_q;
    hsz_d      = hsz_q;
    hnext_d    = hnext_q;
    headnext_d = headnext_q;
    found_d    = found_q;
    szblk_d    = szblk_q;
    cur_d      = cur_q;
    cursz_d    = cursz_q;
    status_d   = status_q;
    addr_d     = addr_q;
    size_we    = 1'b0;
    size_waddr = {a_q, hit_q};
    size_wdata = hsz_q;
    next_we    = 1'b0;
    next_waddr = {a_q, hit_q};
    next_wdata = NIL;
    raddr      = {a_q, it_q[WW-1:0]};
    head_we    = 1'b0;
    head_wval  = NIL;
    mod_value  = KEY_W'(hit_q) + KEY_W'(split_sz);
    unique case (state_q)
      S_INIT: begin
        size_we    = 1'b1;
        size_waddr = {ia_q, WW'(0)};
        size_wdata = cfg_words;
        next_we    = 1'b1;
        next_waddr = {ia_q, WW'(0)};
        next_wdata = NIL;
        ia_d       = ia_q + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          a_d      = arena_red;
          req_d    = req_e'(req_type_i);
          status_d = ST_OK;
          addr_d   = '0;
          words_d  = total[WORDS_W+2:3];
          key_d    = KEY_W'(total[WORDS_W+2:3]);
          mode_d   = WM_FIT;
          cur_d    = blk_ext[WW-1:0];
          if (req_type_i == REQ_ALLOC && too_big) status_d = ST_TOO_BIG;
        end
      end
      S_FHDR: begin
        next_we    = 1'b1;
        next_waddr = {a_q, cur_q};
        next_wdata = NIL;
        raddr      = {a_q, cur_q};
      end
      S_FHDR_RD: begin
        szblk_d = size_rd;
        mode_d  = WM_ENDS_AT;
        key_d   = KEY_W'(cur_q);
      end
      S_WSTART: begin
        it_d    = head_cur;
        prev_d  = '0;
        hp_d    = 1'b0;
        steps_d = '0;
      end
      S_WRD: begin
        if (!in_list) begin
          found_d = 1'b0;
          if (mode_q == WM_FIT) status_d = ST_NO_FIT;
        end
      end
      S_WEV: begin
        if (steps_q == '0) headnext_d = next_rd;
        if (match) begin
          found_d = 1'b1;
          hit_d   = it_q[WW-1:0];
          hsz_d   = size_rd;
          hnext_d = next_rd;
        end else begin
          prev_d  = it_q[WW-1:0];
          hp_d    = 1'b1;
          it_d    = next_rd;
          steps_d = steps_q + 1'b1;
        end
      end
      S_AUNL: begin
        head_we    = unl_head_we;
        head_wval  = unl_head_val;
        next_we    = unl_next_we;
        next_waddr = {a_q, unl_next_addr};
        next_wdata = unl_next_val;
        addr_d     = {hit_p1[ADDR_W-4:0], 3'b000};
      end
      S_ASPLIT: begin
        size_we    = 1'b1;
        size_waddr = {a_q, hit_q};
        size_wdata = split_sz;
        hit_d      = mod_res;
      end
      S_AWR: begin
        size_we    = 1'b1;
        size_waddr = {a_q, hit_q};
        size_wdata = SIZE_W'(words_q);
        addr_d     = {hit_p1[ADDR_W-4:0], 3'b000};
      end
      S_FMERGE1: begin
        mode_d = WM_IS;
        if (found_q) begin
          head_we    = unl_head_we;
          head_wval  = unl_head_val;
          next_we    = unl_next_we;
          next_waddr = {a_q, unl_next_addr};
          next_wdata = unl_next_val;
          size_we    = 1'b1;
          size_waddr = {a_q, hit_q};
          size_wdata = merge1_sz;
          cur_d      = hit_q;
          cursz_d    = merge1_sz;
          key_d      = KEY_W'(hit_q) + KEY_W'(merge1_sz);
        end else begin
          cursz_d = szblk_q;
          key_d   = KEY_W'(cur_q) + KEY_W'(szblk_q);
        end
      end
      S_FMERGE2: begin
        if (found_q) begin
          head_we    = unl_head_we;
          head_wval  = unl_head_val;
          next_we    = unl_next_we;
          next_waddr = {a_q, unl_next_addr};
          next_wdata = unl_next_val;
          size_we    = 1'b1;
          size_waddr = {a_q, cur_q};
          size_wdata = merge2_sz;
          cursz_d    = merge2_sz;
        end
      end
      S_FPUSH: begin
        next_we    = 1'b1;
        next_waddr = {a_q, cur_q};
        next_wdata = head_cur;
        head_we    = 1'b1;
        head_wval  = NB'(cur_q);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
    if (cfg_we_i) ia_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ia_q    <= '0;
      arena_q <= CFG_RESET;
      for (int i = 0; i < ARENAS; i++) begin
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ia_q    <= ia_d;
      if (cfg_we_i) begin
        arena_q <= cfg_wdata_i;
        for (int i = 0; i < ARENAS; i++) begin
          head_q[i] <= '0;
        end
      end else if (head_we) begin
        head_q[a_q] <= head_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    req_q      <= req_d;
    words_q    <= words_d;
    key_q      <= key_d;
    mode_q     <= mode_d;
    it_q       <= it_d;
    prev_q     <= prev_d;
    hp_q       <= hp_d;
    steps_q    <= steps_d;
    hit_q      <= hit_d;
    hsz_q      <= hsz_d;
    hnext_q    <= hnext_d;
    headnext_q <= headnext_d;
    found_q    <= found_d;
    szblk_q    <= szblk_d;
    cur_q      <= cur_d;
    cursz_q    <= cursz_d;
    status_q   <= status_d;
    addr_q     <= addr_d;
  end

  assign busy     = state_q != S_IDLE;
  assign done_o   = state_q == S_DONE;
  assign status_o = status_q;
  assign addr_o   = addr_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !cfg_we_i |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> addr_o == '0)
    else $error("failed allocate returned an address");

  a_free_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && req_q == REQ_FREE |-> status_o == ST_OK && addr_o == '0)
    else $error("free transaction returned a non-ok result");

endmodule
